### rtl/rsm_pkg.sv
package rsm_pkg;

	localparam int SAMPLE_W    = 16;
	localparam int RATE_W      = 19;
	localparam int WORD_W      = 32;
	localparam int CNT_W       = 32;
	localparam int MAX_RATIO   = 16;
	localparam int MAX_RESULTS = 32;

	localparam logic [RATE_W-1:0] DEF_SOURCE_RATE = RATE_W'(16000);
	localparam logic [RATE_W-1:0] RST_SINK_RATE   = RATE_W'(48000);

	localparam logic signed [SAMPLE_W-1:0] SMAX = 16'sh7fff;
	localparam logic signed [SAMPLE_W-1:0] SMIN = 16'sh8000;
	localparam logic [7:0] FLT_EXP_BASE = 8'd112;

	localparam int RATIO_W   = $clog2(MAX_RATIO + 1);
	localparam int FW        = CNT_W + RATIO_W;
	localparam int P_W       = CNT_W + RATE_W;
	localparam int FIRST_W   = P_W + 1;
	localparam int CAP_W     = CNT_W + RATE_W + 3;
	localparam int LERP_W    = SAMPLE_W + RATE_W + 3;
	localparam int DIV_W     = CAP_W;
	localparam int DVS_W     = RATE_W + 1;
	localparam int STEP_W    = $clog2(DIV_W + 1);
	localparam int NUM_W     = FW + RATE_W;
	localparam int MUL_A_W   = FW + 1;
	localparam int MUL_B_W   = RATE_W + 2;
	localparam int PROD_W    = MUL_A_W + MUL_B_W;
	localparam int RES_CNT_W = $clog2(MAX_RESULTS + 1);

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_RATE   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_SINK_RATE     = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SOURCE_STEREO = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SINK_STEREO   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_FLOAT_OUTPUT  = 3'd4;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] left;
		logic signed [SAMPLE_W-1:0] right;
		logic                       last;
		logic [RATE_W-1:0]          s;
		logic [RATE_W-1:0]          d;
	} item_t;

	typedef struct packed {
		logic sink_stereo;
		logic float_out;
	} mode_t;

endpackage

### rtl/rsm_if.sv
interface rsm_in_if;
	logic                                valid;
	logic                                ready;
	logic signed [rsm_pkg::SAMPLE_W-1:0] left_sample;
	logic signed [rsm_pkg::SAMPLE_W-1:0] right_sample;
	logic                                block_end;

	modport source(output valid, left_sample, right_sample, block_end, input ready);
	modport sink(input valid, left_sample, right_sample, block_end, output ready);
endinterface

interface rsm_out_if;
	logic                        valid;
	logic                        ready;
	logic [rsm_pkg::WORD_W-1:0]  out_left_word;
	logic [rsm_pkg::WORD_W-1:0]  out_right_word;
	logic                        run_last;
	logic                        block_done;

	modport source(output valid, out_left_word, out_right_word, run_last, block_done,
		input ready);
	modport sink(input valid, out_left_word, out_right_word, run_last, block_done,
		output ready);
endinterface

### rtl/rsm_front.sv
module rsm_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rsm_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [rsm_pkg::RATE_W-1:0]      cfg_data,
	rsm_in_if.sink                          src,
	input  logic                            full,
	output logic                            push,
	output rsm_pkg::item_t                  item,
	output rsm_pkg::mode_t                  mode
);

	logic [rsm_pkg::RATE_W-1:0] src_rate_q;
	logic [rsm_pkg::RATE_W-1:0] snk_rate_q;
	logic src_st_q;
	logic snk_st_q;
	logic flt_q;

	logic [rsm_pkg::RATE_W-1:0]                  s_eff;
	logic [rsm_pkg::RATE_W+rsm_pkg::RATIO_W-1:0] lim;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_rate_q <= rsm_pkg::DEF_SOURCE_RATE;
			snk_rate_q <= rsm_pkg::RST_SINK_RATE;
			src_st_q   <= 1'b1;
			snk_st_q   <= 1'b1;
			flt_q      <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rsm_pkg::REG_SOURCE_RATE:   src_rate_q <= cfg_data;
				rsm_pkg::REG_SINK_RATE:     snk_rate_q <= cfg_data;
				rsm_pkg::REG_SOURCE_STEREO: src_st_q   <= cfg_data[0];
				rsm_pkg::REG_SINK_STEREO:   snk_st_q   <= cfg_data[0];
				rsm_pkg::REG_FLOAT_OUTPUT:  flt_q      <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		s_eff = (src_rate_q == '0) ? rsm_pkg::DEF_SOURCE_RATE : src_rate_q;
		lim = (rsm_pkg::RATE_W+rsm_pkg::RATIO_W)'(s_eff)
			* (rsm_pkg::RATE_W+rsm_pkg::RATIO_W)'(rsm_pkg::MAX_RATIO);
		item.left  = src.left_sample;
		item.right = src_st_q ? src.right_sample : src.left_sample;
		item.last  = src.block_end;
		item.s     = s_eff;
		if ((rsm_pkg::RATE_W+rsm_pkg::RATIO_W)'(snk_rate_q) > lim) begin
			item.d = lim[rsm_pkg::RATE_W-1:0];
		end else begin
			item.d = snk_rate_q;
		end
	end

	assign src.ready = !full;
	assign push      = src.valid && !full;
	assign mode      = '{sink_stereo: snk_st_q, float_out: flt_q};

endmodule

### rtl/rsm_queue.sv
module rsm_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  rsm_pkg::item_t wr_item,
	output logic           full,
	input  logic           pop,
	output rsm_pkg::item_t rd_item,
	output logic           empty
);

	rsm_pkg::item_t mem_q [rsm_pkg::QDEPTH];
	logic [rsm_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [rsm_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [rsm_pkg::QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= wr_item;
	end

	assign rd_item = mem_q[rd_ptr_q];
	assign full    = (cnt_q == rsm_pkg::QCNT_W'(rsm_pkg::QDEPTH));
	assign empty   = (cnt_q == '0);

endmodule

### rtl/rsm_div.sv
module rsm_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rsm_pkg::DIV_W-1:0]    dividend,
	input  logic [rsm_pkg::DVS_W-1:0]    divisor,
	input  logic [rsm_pkg::STEP_W-1:0]   steps,
	output logic                         done,
	output logic [rsm_pkg::DIV_W-1:0]    quotient
);

	logic [rsm_pkg::DVS_W-1:0]  rem_q;
	logic [rsm_pkg::DVS_W-1:0]  dvs_q;
	logic [rsm_pkg::DIV_W-1:0]  sh_q;
	logic [rsm_pkg::STEP_W-1:0] cnt_q;
	logic busy_q;
	logic done_q;

	logic [rsm_pkg::DVS_W:0] trial;
	logic [rsm_pkg::DVS_W:0] diff;
	logic ge;

	always_comb begin
		trial = {rem_q, sh_q[rsm_pkg::DIV_W-1]};
		diff  = trial - {1'b0, dvs_q};
		ge    = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvs_q  <= '0;
			sh_q   <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			rem_q  <= '0;
			dvs_q  <= divisor;
			sh_q   <= dividend;
			cnt_q  <= steps;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[rsm_pkg::DVS_W-1:0] : trial[rsm_pkg::DVS_W-1:0];
			sh_q  <= {sh_q[rsm_pkg::DIV_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == rsm_pkg::STEP_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

### rtl/rsm_back.sv
module rsm_back (
	input  logic           clk,
	input  logic           arst_n,
	input  rsm_pkg::item_t q_item,
	input  logic           q_empty,
	output logic           q_pop,
	input  rsm_pkg::mode_t mode,
	rsm_out_if.source      snk
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_CAP_M = 4'd1;
	localparam logic [3:0] ST_CAP_D = 4'd2;
	localparam logic [3:0] ST_GSEL  = 4'd3;
	localparam logic [3:0] ST_P_M   = 4'd4;
	localparam logic [3:0] ST_F_D   = 4'd5;
	localparam logic [3:0] ST_F_M   = 4'd6;
	localparam logic [3:0] ST_NUM   = 4'd7;
	localparam logic [3:0] ST_LCHK  = 4'd8;
	localparam logic [3:0] ST_L_M1  = 4'd9;
	localparam logic [3:0] ST_L_M2  = 4'd10;
	localparam logic [3:0] ST_L_D   = 4'd11;
	localparam logic [3:0] ST_EMIT  = 4'd12;
	localparam logic [3:0] ST_FIN   = 4'd13;

	localparam logic [1:0] PH_A    = 2'd0;
	localparam logic [1:0] PH_B    = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	localparam int SW = rsm_pkg::SAMPLE_W;
	localparam int WW = rsm_pkg::WORD_W;

	function automatic logic [WW-1:0] encode(input logic signed [SW-1:0] v, input logic fl);
		logic [SW:0]   mag;
		logic [3:0]    p;
		logic [7:0]    ex;
		logic [WW-1:0] shf;
		logic [WW-1:0] res;
		mag = v[SW-1] ? ((SW+1)'(0) - (SW+1)'(v)) : (SW+1)'(v);
		p = '0;
		for (int j = 1; j < SW; j++) begin
			if (mag[j]) p = 4'(j);
		end
		ex  = rsm_pkg::FLT_EXP_BASE + 8'(p);
		shf = WW'(mag) << (5'd23 - 5'(p));
		res = {v[SW-1], ex, shf[22:0]};
		if (!fl) res = WW'(v);
		else if (v == '0) res = '0;
		return res;
	endfunction

	logic [3:0] state_q;
	logic [1:0] phase_q;
	rsm_pkg::item_t cur_q;
	logic signed [SW-1:0] prev_l_q, prev_r_q, a_l_q, a_r_q, b_l_q, b_r_q, l_q, r_q;
	logic have_prev_q;
	logic [rsm_pkg::CNT_W-1:0] k_q, f_q, i_q;
	logic [rsm_pkg::FW-1:0] fc_q, cap_q;
	logic capped_q;
	logic [rsm_pkg::P_W-1:0] p_q;
	logic [rsm_pkg::NUM_W-1:0] num_q;
	logic [rsm_pkg::RES_CNT_W-1:0] n_q;
	logic ch_q;

	logic signed [rsm_pkg::MUL_A_W-1:0] mul_a;
	logic signed [rsm_pkg::MUL_B_W-1:0] mul_b;
	logic signed [rsm_pkg::PROD_W-1:0]  mul_out, prod_q;
	logic signed [SW:0]                 diff_w;
	logic signed [rsm_pkg::LERP_W-1:0]  t_q;
	logic [rsm_pkg::LERP_W-1:0]         mag_w;
	logic [rsm_pkg::FIRST_W-1:0]        first_dvd;

	logic div_start, div_run_q, div_done;
	logic [rsm_pkg::DIV_W-1:0]  div_dvd, div_quo;
	logic [rsm_pkg::DVS_W-1:0]  div_dvs;
	logic [rsm_pkg::STEP_W-1:0] div_steps;

	logic [SW:0]          q17;
	logic signed [SW+1:0] sv;
	logic signed [SW-1:0] sat;
	logic signed [SW:0]   sum_w, sum_adj;
	logic signed [SW-1:0] mix;
	logic [WW-1:0] new_lw, new_rw;
	logic go;

	logic pend_v_q;
	logic [WW-1:0] pend_lw_q, pend_rw_q;
	logic out_v_q, out_rl_q, out_bd_q;
	logic [WW-1:0] out_lw_q, out_rw_q;
	logic out_free, out_push;

	rsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.steps    (div_steps),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		diff_w = ch_q ? ((SW+1)'(b_r_q) - (SW+1)'(a_r_q)) : ((SW+1)'(b_l_q) - (SW+1)'(a_l_q));
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_CAP_M: begin
				mul_a = rsm_pkg::MUL_A_W'(k_q) + rsm_pkg::MUL_A_W'(1);
				mul_b = rsm_pkg::MUL_B_W'({cur_q.d, 1'b0});
			end
			ST_P_M: begin
				mul_a = rsm_pkg::MUL_A_W'(i_q);
				mul_b = rsm_pkg::MUL_B_W'(cur_q.d);
			end
			ST_F_M: begin
				mul_a = rsm_pkg::MUL_A_W'(fc_q);
				mul_b = rsm_pkg::MUL_B_W'(cur_q.s);
			end
			ST_L_M1: begin
				mul_a = rsm_pkg::MUL_A_W'(ch_q ? a_r_q : a_l_q);
				mul_b = rsm_pkg::MUL_B_W'(cur_q.d);
			end
			ST_L_M2: begin
				mul_a = rsm_pkg::MUL_A_W'(diff_w);
				mul_b = rsm_pkg::MUL_B_W'(num_q[rsm_pkg::RATE_W-1:0]);
			end
			default: ;
		endcase
		mul_out = mul_a * mul_b;
	end

	always_comb begin
		mag_w = t_q[rsm_pkg::LERP_W-1] ? rsm_pkg::LERP_W'(-t_q) : rsm_pkg::LERP_W'(t_q);
		first_dvd = rsm_pkg::FIRST_W'(prod_q[rsm_pkg::P_W-1:0])
			+ rsm_pkg::FIRST_W'(cur_q.s) - rsm_pkg::FIRST_W'(1);
		div_dvd   = '0;
		div_dvs   = '0;
		div_steps = '0;
		unique case (state_q)
			ST_CAP_D: begin
				div_dvd = (rsm_pkg::DIV_W'(prod_q[rsm_pkg::CAP_W-1:0])
					+ rsm_pkg::DIV_W'(cur_q.s)) << (rsm_pkg::DIV_W - rsm_pkg::CAP_W);
				div_dvs   = {cur_q.s, 1'b0};
				div_steps = rsm_pkg::STEP_W'(rsm_pkg::CAP_W);
			end
			ST_F_D: begin
				div_dvd   = rsm_pkg::DIV_W'(first_dvd) << (rsm_pkg::DIV_W - rsm_pkg::FIRST_W);
				div_dvs   = rsm_pkg::DVS_W'(cur_q.s);
				div_steps = rsm_pkg::STEP_W'(rsm_pkg::FIRST_W);
			end
			ST_L_D: begin
				div_dvd = rsm_pkg::DIV_W'((mag_w << 1) + rsm_pkg::LERP_W'(cur_q.d))
					<< (rsm_pkg::DIV_W - rsm_pkg::LERP_W);
				div_dvs   = {cur_q.d, 1'b0};
				div_steps = rsm_pkg::STEP_W'(rsm_pkg::LERP_W);
			end
			default: ;
		endcase
		div_start = (state_q == ST_CAP_D || state_q == ST_F_D || state_q == ST_L_D)
			&& !div_run_q;
	end

	always_comb begin
		q17 = div_quo[SW:0];
		sv  = t_q[rsm_pkg::LERP_W-1] ? -$signed({1'b0, q17}) : $signed({1'b0, q17});
		if (sv > (SW+2)'(rsm_pkg::SMAX)) sat = rsm_pkg::SMAX;
		else if (sv < (SW+2)'(rsm_pkg::SMIN)) sat = rsm_pkg::SMIN;
		else sat = sv[SW-1:0];
		sum_w   = (SW+1)'(l_q) + (SW+1)'(r_q);
		sum_adj = sum_w + (SW+1)'(sum_w[SW]);
		mix     = sum_adj[SW:1];
		new_lw  = mode.sink_stereo ? encode(l_q, mode.float_out) : encode(mix, mode.float_out);
		new_rw  = mode.sink_stereo ? encode(r_q, mode.float_out) : '0;
		go = (num_q < rsm_pkg::NUM_W'(cur_q.d)) && !(capped_q && fc_q >= cap_q)
			&& (n_q < rsm_pkg::RES_CNT_W'(rsm_pkg::MAX_RESULTS));
	end

	assign out_free = !out_v_q || snk.ready;
	assign out_push = (state_q == ST_EMIT || state_q == ST_FIN) && pend_v_q && out_free;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_A;
			cur_q       <= '0;
			prev_l_q    <= '0;
			prev_r_q    <= '0;
			a_l_q       <= '0;
			a_r_q       <= '0;
			b_l_q       <= '0;
			b_r_q       <= '0;
			l_q         <= '0;
			r_q         <= '0;
			have_prev_q <= 1'b0;
			k_q         <= '0;
			f_q         <= '0;
			i_q         <= '0;
			fc_q        <= '0;
			cap_q       <= '0;
			capped_q    <= 1'b0;
			p_q         <= '0;
			num_q       <= '0;
			n_q         <= '0;
			ch_q        <= 1'b0;
			prod_q      <= '0;
			t_q         <= '0;
			div_run_q   <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_lw_q   <= '0;
			pend_rw_q   <= '0;
			out_v_q     <= 1'b0;
			out_lw_q    <= '0;
			out_rw_q    <= '0;
			out_rl_q    <= 1'b0;
			out_bd_q    <= 1'b0;
		end else begin
			if (div_start) div_run_q <= 1'b1;
			else if (div_done) div_run_q <= 1'b0;

			if (out_push) begin
				out_v_q  <= 1'b1;
				out_lw_q <= pend_lw_q;
				out_rw_q <= pend_rw_q;
				out_rl_q <= (state_q == ST_FIN);
				out_bd_q <= (state_q == ST_FIN) && cur_q.last;
			end else if (snk.ready) begin
				out_v_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cur_q    <= q_item;
						n_q      <= '0;
						fc_q     <= rsm_pkg::FW'(f_q);
						phase_q  <= PH_A;
						capped_q <= 1'b0;
						state_q  <= q_item.last ? ST_CAP_M : ST_GSEL;
					end
				end
				ST_CAP_M: begin
					prod_q  <= mul_out;
					state_q <= ST_CAP_D;
				end
				ST_CAP_D: begin
					if (div_done) begin
						cap_q   <= div_quo[rsm_pkg::FW-1:0];
						state_q <= ST_GSEL;
					end
				end
				ST_GSEL: begin
					unique case (phase_q)
						PH_A: begin
							phase_q <= PH_B;
							if (have_prev_q && k_q != '0) begin
								i_q      <= k_q - 1'b1;
								a_l_q    <= prev_l_q;
								a_r_q    <= prev_r_q;
								b_l_q    <= cur_q.left;
								b_r_q    <= cur_q.right;
								capped_q <= cur_q.last;
								state_q  <= ST_P_M;
							end
						end
						PH_B: begin
							phase_q <= PH_DONE;
							if (cur_q.last) begin
								i_q      <= k_q;
								a_l_q    <= cur_q.left;
								a_r_q    <= cur_q.right;
								b_l_q    <= cur_q.left;
								b_r_q    <= cur_q.right;
								capped_q <= 1'b1;
								state_q  <= ST_P_M;
							end
						end
						default: state_q <= ST_FIN;
					endcase
				end
				ST_P_M: begin
					prod_q  <= mul_out;
					state_q <= ST_F_D;
				end
				ST_F_D: begin
					if (div_done) begin
						p_q <= prod_q[rsm_pkg::P_W-1:0];
						if (fc_q < div_quo[rsm_pkg::FW-1:0]) fc_q <= div_quo[rsm_pkg::FW-1:0];
						state_q <= ST_F_M;
					end
				end
				ST_F_M: begin
					prod_q  <= mul_out;
					state_q <= ST_NUM;
				end
				ST_NUM: begin
					num_q   <= prod_q[rsm_pkg::NUM_W-1:0] - rsm_pkg::NUM_W'(p_q);
					state_q <= ST_LCHK;
				end
				ST_LCHK: begin
					if (go) begin
						ch_q    <= 1'b0;
						state_q <= ST_L_M1;
					end else begin
						state_q <= ST_GSEL;
					end
				end
				ST_L_M1: begin
					prod_q  <= mul_out;
					state_q <= ST_L_M2;
				end
				ST_L_M2: begin
					t_q     <= prod_q[rsm_pkg::LERP_W-1:0] + mul_out[rsm_pkg::LERP_W-1:0];
					state_q <= ST_L_D;
				end
				ST_L_D: begin
					if (div_done) begin
						if (ch_q) begin
							r_q     <= sat;
							state_q <= ST_EMIT;
						end else begin
							l_q     <= sat;
							ch_q    <= 1'b1;
							state_q <= ST_L_M1;
						end
					end
				end
				ST_EMIT: begin
					if (!pend_v_q || out_free) begin
						pend_v_q  <= 1'b1;
						pend_lw_q <= new_lw;
						pend_rw_q <= new_rw;
						fc_q      <= fc_q + 1'b1;
						num_q     <= num_q + rsm_pkg::NUM_W'(cur_q.s);
						n_q       <= n_q + 1'b1;
						state_q   <= ST_LCHK;
					end
				end
				ST_FIN: begin
					if (!pend_v_q || out_free) begin
						pend_v_q <= 1'b0;
						if (cur_q.last) begin
							have_prev_q <= 1'b0;
							k_q         <= '0;
							f_q         <= '0;
						end else begin
							prev_l_q    <= cur_q.left;
							prev_r_q    <= cur_q.right;
							have_prev_q <= 1'b1;
							k_q         <= k_q + 1'b1;
							f_q         <= fc_q[rsm_pkg::CNT_W-1:0];
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign snk.valid          = out_v_q;
	assign snk.out_left_word  = out_lw_q;
	assign snk.out_right_word = out_rw_q;
	assign snk.run_last       = out_rl_q;
	assign snk.block_done     = out_bd_q;

endmodule

### rtl/linear_resampler_channel_mapper_unit.sv
// Per source frame: a start-position division for each interpolation segment, plus a
// block length division on a block-end frame.
// Each output frame then needs two 38-step divisions in the shared bit-serial divider,
// which sets the rate. A request is taken while the queue has room.
// Reset is asynchronous, active low: registers go to 16000 Hz, 48000 Hz, stereo in and
// out, int16 words, and the block state clears.
module linear_resampler_channel_mapper_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [rsm_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [rsm_pkg::RATE_W-1:0]      cfg_data,
	rsm_in_if.sink                          src,
	rsm_out_if.source                       snk
);

	rsm_pkg::item_t wr_item;
	rsm_pkg::item_t rd_item;
	rsm_pkg::mode_t mode;
	logic push, full, pop, empty;

	rsm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.src       (src),
		.full      (full),
		.push      (push),
		.item      (wr_item),
		.mode      (mode)
	);

	rsm_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (wr_item),
		.full    (full),
		.pop     (pop),
		.rd_item (rd_item),
		.empty   (empty)
	);

	rsm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_item  (rd_item),
		.q_empty (empty),
		.q_pop   (pop),
		.mode    (mode),
		.snk     (snk)
	);

`ifndef ASSERT_OFF
	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		snk.valid && snk.block_done |-> snk.run_last)
		else $error("block_done without run_last");

	a_mono_right_zero: assert property (@(posedge clk) disable iff (!arst_n)
		snk.valid && !mode.sink_stereo |-> snk.out_right_word == '0)
		else $error("right word not zero for mono sink");

	a_int_sign_ext: assert property (@(posedge clk) disable iff (!arst_n)
		snk.valid && !mode.float_out |->
		(snk.out_left_word[31:15] == '0 || snk.out_left_word[31:15] == '1))
		else $error("int16 left word not sign extended");
`endif

endmodule

### tb/linear_resampler_channel_mapper_unit_tb.sv
`timescale 1ns / 1ps

module linear_resampler_channel_mapper_unit_tb;

	typedef struct {
		logic signed [rsm_pkg::SAMPLE_W-1:0] left;
		logic signed [rsm_pkg::SAMPLE_W-1:0] right;
		bit                                  last;
	} frame_t;

	typedef struct {
		logic [rsm_pkg::WORD_W-1:0] lw;
		logic [rsm_pkg::WORD_W-1:0] rw;
		bit                         run_last;
		bit                         done;
	} out_frame_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [rsm_pkg::REG_IDX_W-1:0] cfg_index;
	logic [rsm_pkg::RATE_W-1:0] cfg_data;

	rsm_in_if in_ch();
	rsm_out_if out_ch();

	linear_resampler_channel_mapper_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.src(in_ch.source),
		.snk(out_ch.sink)
	);

	frame_t source_frames[$];
	out_frame_t expected_frames[$];
	out_frame_t batch[$];

	longint src_rate_r, sink_rate_r;
	bit src_stereo_r, sink_stereo_r, float_r;
	int prev_l, prev_r;
	bit have_prev;
	longint src_idx, out_idx;

	int mismatches;
	int idle_cycles;
	bit accepted_in;
	int burst_left, gap_left;
	int ready_cnt;
	bit stall_mode;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int interp(int a, int b, longint num, longint d);
		longint t, q;
		t = longint'(a) * d + longint'(b - a) * num;
		if (t >= 0)
			q = (2 * t + d) / (2 * d);
		else
			q = -((-2 * t + d) / (2 * d));
		if (q > 32767) q = 32767;
		if (q < -32768) q = -32768;
		return int'(q);
	endfunction

	function automatic logic [rsm_pkg::WORD_W-1:0] encode_word(int v);
		int unsigned mag, p, sgn;
		if (!float_r)
			return rsm_pkg::WORD_W'(v);
		if (v == 0)
			return '0;
		sgn = v < 0 ? 32'h8000_0000 : 0;
		mag = v < 0 ? -v : v;
		p = 0;
		while (p < 15 && (mag >> (p + 1)) != 0)
			p++;
		return sgn | ((127 + p - 15) << 23) | ((mag << (23 - p)) & 32'h7f_ffff);
	endfunction

	function automatic void segment_frames(inout longint f, input longint i, input int al,
		input int ar, input int bl, input int br, input bit capped, input longint cap,
		input longint s, input longint d);
		longint first, num;
		int l, r, m;
		out_frame_t o;
		first = (i * d + s - 1) / s;
		if (f < first)
			f = first;
		while (batch.size() < rsm_pkg::MAX_RESULTS) begin
			if (f * s >= (i + 1) * d)
				break;
			if (capped && f >= cap)
				break;
			num = f * s - i * d;
			l = interp(al, bl, num, d);
			r = interp(ar, br, num, d);
			if (sink_stereo_r) begin
				o.lw = encode_word(l);
				o.rw = encode_word(r);
			end else begin
				m = src_stereo_r ? (l + r) / 2 : l;
				o.lw = encode_word(m);
				o.rw = '0;
			end
			o.run_last = 0;
			o.done = 0;
			batch.push_back(o);
			f++;
		end
	endfunction

	function automatic void resample_frame(int cl, int cr_in, bit last);
		int cr;
		longint s, d, k, f, cap;
		cr = src_stereo_r ? cr_in : cl;
		s = src_rate_r != 0 ? src_rate_r : 16000;
		d = sink_rate_r;
		if (d > rsm_pkg::MAX_RATIO * s)
			d = rsm_pkg::MAX_RATIO * s;
		k = src_idx;
		f = out_idx;
		cap = 0;
		batch.delete();
		if (last)
			cap = (2 * (k + 1) * d + s) / (2 * s);
		if (have_prev && k > 0)
			segment_frames(f, k - 1, prev_l, prev_r, cl, cr, last, cap, s, d);
		if (last) begin
			segment_frames(f, k, cl, cr, cl, cr, 1'b1, cap, s, d);
			if (batch.size() > 0)
				batch[batch.size() - 1].done = 1;
			have_prev = 0;
			src_idx = 0;
			out_idx = 0;
		end else begin
			prev_l = cl;
			prev_r = cr;
			have_prev = 1;
			src_idx = (k + 1) & 64'hffff_ffff;
			out_idx = f & 64'hffff_ffff;
		end
		if (batch.size() > 0)
			batch[batch.size() - 1].run_last = 1;
		foreach (batch[j])
			expected_frames.push_back(batch[j]);
	endfunction

	task automatic write_reg(logic [rsm_pkg::REG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= rsm_pkg::RATE_W'(val);
		case (idx)
			rsm_pkg::REG_SOURCE_RATE: src_rate_r = val;
			rsm_pkg::REG_SINK_RATE: sink_rate_r = val;
			rsm_pkg::REG_SOURCE_STEREO: src_stereo_r = val[0];
			rsm_pkg::REG_SINK_STEREO: sink_stereo_r = val[0];
			rsm_pkg::REG_FLOAT_OUTPUT: float_r = val[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(int unsigned sr, int unsigned dr, bit ss, bit ks, bit fl);
		write_reg(rsm_pkg::REG_SOURCE_RATE, sr);
		write_reg(rsm_pkg::REG_SINK_RATE, dr);
		write_reg(rsm_pkg::REG_SOURCE_STEREO, ss);
		write_reg(rsm_pkg::REG_SINK_STEREO, ks);
		write_reg(rsm_pkg::REG_FLOAT_OUTPUT, fl);
	endtask

	function automatic logic signed [rsm_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 7))
			0: return rsm_pkg::SMAX;
			1: return rsm_pkg::SMIN;
			2: return 16'sd0;
			default: return rsm_pkg::SAMPLE_W'($urandom);
		endcase
	endfunction

	task automatic push_frame(logic signed [rsm_pkg::SAMPLE_W-1:0] l,
		logic signed [rsm_pkg::SAMPLE_W-1:0] r, bit last);
		frame_t fr;
		fr.left = l;
		fr.right = r;
		fr.last = last;
		source_frames.push_back(fr);
	endtask

	task automatic add_block(int n);
		for (int j = 0; j < n; j++)
			push_frame(rand_sample(), rand_sample(), j == n - 1);
	endtask

	task automatic drain();
		while (source_frames.size() != 0 || in_ch.valid || expected_frames.size() != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
	endtask

	initial begin
		int unsigned sr, dr;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.left_sample = '0;
		in_ch.right_sample = '0;
		in_ch.block_end = 1'b0;
		out_ch.ready = 1'b0;
		src_rate_r = 16000;
		sink_rate_r = 48000;
		src_stereo_r = 1;
		sink_stereo_r = 1;
		float_r = 0;
		have_prev = 0;
		src_idx = 0;
		out_idx = 0;
		mismatches = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		push_frame(rsm_pkg::SMAX, rsm_pkg::SMIN, 0);
		push_frame(rsm_pkg::SMIN, rsm_pkg::SMAX, 0);
		push_frame(16'sd0, 16'sd0, 0);
		push_frame(rsm_pkg::SMAX, rsm_pkg::SMAX, 1);
		push_frame(16'sd1, -16'sd1, 1);
		push_frame(rsm_pkg::SMIN, rsm_pkg::SMIN, 0);
		push_frame(rsm_pkg::SMAX, 16'sd3, 1);
		drain();

		// ratio clamps to 16, zero source rate, float mono
		configure(0, 384000, 0, 0, 1);
		push_frame(rsm_pkg::SMIN, rsm_pkg::SMAX, 0);
		push_frame(rsm_pkg::SMAX, rsm_pkg::SMIN, 0);
		push_frame(-16'sd1, 16'sd5, 1);
		drain();

		configure(4, 1, 1, 0, 1);
		push_frame(rsm_pkg::SMAX, rsm_pkg::SMAX, 1);
		push_frame(rsm_pkg::SMAX, rsm_pkg::SMIN, 0);
		push_frame(rsm_pkg::SMIN, 16'sd1, 0);
		push_frame(16'sd7, 16'sd9, 1);
		drain();

		configure(16000, 0, 1, 1, 0);
		push_frame(rsm_pkg::SMAX, rsm_pkg::SMIN, 0);
		push_frame(16'sd1, 16'sd2, 1);
		drain();

		configure(384000, 1, 0, 1, 1);
		add_block(3);
		drain();

		configure(3, 2, 1, 1, 1);
		add_block(4);
		add_block(1);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			case ($urandom_range(0, 3))
				0: sr = 0;
				1: sr = 384000;
				2: sr = $urandom_range(1, 50);
				default: sr = $urandom_range(1, 384000);
			endcase
			case ($urandom_range(0, 3))
				0: dr = 384000;
				1: dr = $urandom_range(1, 4) * (sr == 0 ? 16000 : sr);
				2: dr = $urandom_range(1, 100);
				default: dr = $urandom_range(1, 384000);
			endcase
			if (dr > 384000)
				dr = 384000;
			configure(sr, dr, $urandom_range(0, 1), $urandom_range(0, 1),
				$urandom_range(0, 1));
			for (int b = 0; b < 5; b++)
				add_block($urandom_range(0, 3) == 0 ? 1 : $urandom_range(2, 8));
			drain();
		end

		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			if (expected_frames.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result %h %h", out_ch.out_left_word,
						out_ch.out_right_word);
			end else begin
				out_frame_t e;
				e = expected_frames.pop_front();
				if (e.lw !== out_ch.out_left_word || e.rw !== out_ch.out_right_word ||
					e.run_last !== out_ch.run_last || e.done !== out_ch.block_done) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %b %b, got %h %h %b %b",
							e.lw, e.rw, e.run_last, e.done, out_ch.out_left_word,
							out_ch.out_right_word, out_ch.run_last, out_ch.block_done);
				end
			end
		end
		if (in_ch.valid && in_ch.ready)
			resample_frame(in_ch.left_sample, in_ch.right_sample, in_ch.block_end);
		accepted_in <= in_ch.valid && in_ch.ready;
	end

	always @(negedge clk) begin
		bit v;
		if (!arst_n) begin
			burst_left = 0;
			gap_left = 0;
		end else begin
			v = in_ch.valid;
			if (accepted_in) begin
				source_frames.pop_front();
				v = 0;
			end
			if (!v) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (source_frames.size() > 0) begin
					v = 1;
					in_ch.left_sample <= source_frames[0].left;
					in_ch.right_sample <= source_frames[0].right;
					in_ch.block_end <= source_frames[0].last;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 6);
						gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300);
					end
				end
			end
			in_ch.valid <= v;
			ready_cnt++;
			if (ready_cnt % 200 == 0)
				stall_mode = $urandom_range(0, 2) != 0;
			out_ch.ready <= stall_mode ? ($urandom_range(0, 99) < 40) : 1'b1;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 30000) begin
			$display("Verification failed");
			$finish;
		end
	end

endmodule

### linear_resampler_channel_mapper_unit.f
rtl/rsm_pkg.sv
rtl/rsm_if.sv
rtl/rsm_front.sv
rtl/rsm_queue.sv
rtl/rsm_div.sv
rtl/rsm_back.sv
rtl/linear_resampler_channel_mapper_unit.sv
tb/linear_resampler_channel_mapper_unit_tb.sv
